[design/eam_pkg.sv]
// ----------------------------------------------------------------------------
// Exclusive access monitor package
// Shared sizes, request codes and the types passed between the top level and
// the table cells.
// ----------------------------------------------------------------------------
package eam_pkg;

  localparam int TABLE_ENTRIES = 16;
  localparam int CPU_COUNT     = 16;

  localparam int MODE_W = 2;
  localparam int CPU_W  = 4;
  localparam int ADDR_W = 32;
  localparam int WORD_W = ADDR_W - 2;
  localparam int OCC_W  = 5;

  localparam int IDX_W = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1;
  localparam int CNT_W = ($clog2(TABLE_ENTRIES + 1) > OCC_W) ?
                         $clog2(TABLE_ENTRIES + 1) : OCC_W;

  localparam int IN_BITS  = MODE_W + CPU_W + ADDR_W;
  localparam int IN_TDATA_W  = ((IN_BITS + 7) / 8) * 8;
  localparam int OUT_BITS = 3 + OCC_W;
  localparam int OUT_TDATA_W = ((OUT_BITS + 7) / 8) * 8;

  localparam logic [MODE_W-1:0] MODE_MARK  = 2'd0;
  localparam logic [MODE_W-1:0] MODE_TEST  = 2'd1;
  localparam logic [MODE_W-1:0] MODE_CLEAR = 2'd2;

  typedef struct packed {
    logic              do_append;
    logic              do_clear;
    logic [WORD_W-1:0] word;
    logic [CPU_W-1:0]  cpu;
    logic [CNT_W-1:0]  count;
  } cell_ctl_t;

  typedef struct packed {
    logic hit;
    logic own;
  } chain_t;

endpackage

[design/eam_cell.sv]
// ----------------------------------------------------------------------------
// Exclusive access monitor table cell
// Holds one entry, compares it with the request, passes hit status up the row,
// and takes its upper neighbor's entry when it or a lower entry is cleared.
// ----------------------------------------------------------------------------
module eam_cell
  import eam_pkg::*;
(
  input  logic              clk,
  input  logic [IDX_W-1:0]  index,
  input  cell_ctl_t         ctl,
  input  logic [WORD_W-1:0] next_word,
  input  logic [CPU_W-1:0]  next_owner,
  input  chain_t            chain_in,
  output chain_t            chain_out,
  output logic [WORD_W-1:0] word,
  output logic [CPU_W-1:0]  owner
);

  logic in_use;
  logic match;

  assign in_use = CNT_W'(index) < ctl.count;
  assign match  = in_use && (word == ctl.word);

  assign chain_out.hit = chain_in.hit | match;
  assign chain_out.own = chain_in.own | (match && (owner == ctl.cpu));

  always_ff @(posedge clk) begin
    if (ctl.do_append && (CNT_W'(index) == ctl.count)) begin
      word  <= ctl.word;
      owner <= ctl.cpu;
    end else if (ctl.do_clear && chain_out.hit) begin
      word  <= next_word;
      owner <= next_owner;
    end
  end

endmodule

[design/exclusive_access_monitor.sv]
// ----------------------------------------------------------------------------
// Exclusive access monitor
// Global monitor for exclusive loads and stores, built as a row of cells.
// ----------------------------------------------------------------------------
// Requests arrive on the s_ channel as beats of {address, cpu_id, mode}.
// Mode mark records the word address for the cpu unless it is already held,
// mode test reports fail unless the word is held by that cpu, and mode clear
// removes the entry, the cells above it moving down one place.
// Each request gives one result beat on the m_ channel with fail, not_found,
// full_res and the table occupancy after the request.
// A request is registered at acceptance and searched in all cells in the
// next cycle, and its result is registered in the output register and
// offered on the m_ channel. The monitor takes no new request while one is
// in the compare-and-update step of the cell row that follows the request
// register.
// A result waiting in the output register holds off the next request until
// it is taken, so a stalled receiver stalls the request channel.
// Reset empties the table and drops any pending result.
// ----------------------------------------------------------------------------
module exclusive_access_monitor
  import eam_pkg::*;
(
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   s_tvalid,
  output logic                   s_tready,
  input  logic [IN_TDATA_W-1:0]  s_tdata,   // mode, cpu_id, address, zero pad
  output logic                   m_tvalid,
  input  logic                   m_tready,
  output logic [OUT_TDATA_W-1:0] m_tdata    // fail, not_found, full_res, occupancy
);

  logic              busy;
  logic [MODE_W-1:0] req_mode;
  logic [CPU_W-1:0]  req_cpu;
  logic [WORD_W-1:0] req_word;
  logic [CNT_W-1:0]  count;
  logic [CNT_W-1:0]  count_next;

  logic              res_fail;
  logic              res_not_found;
  logic              res_full;
  logic [OCC_W-1:0]  res_occ;

  cell_ctl_t         ctl;
  chain_t            chain [TABLE_ENTRIES+1];
  logic [WORD_W-1:0] cell_word  [TABLE_ENTRIES];
  logic [CPU_W-1:0]  cell_owner [TABLE_ENTRIES];

  logic accept;
  logic is_mark;
  logic is_test;
  logic is_clear;
  logic hit;
  logic is_full;

  assign s_tready = !busy && (!m_tvalid || m_tready);
  assign accept   = s_tvalid && s_tready;

  assign is_mark  = busy && (req_mode == MODE_MARK);
  assign is_test  = busy && (req_mode == MODE_TEST);
  assign is_clear = busy && (req_mode == MODE_CLEAR);
  assign hit      = chain[TABLE_ENTRIES].hit;
  assign is_full  = count == CNT_W'(TABLE_ENTRIES);

  always_comb begin
    ctl.do_append = is_mark && !hit && !is_full;
    ctl.do_clear  = is_clear && hit;
    ctl.word      = req_word;
    ctl.cpu       = req_cpu;
    ctl.count     = count;
  end

  always_comb begin
    count_next = count;
    if (ctl.do_append) begin
      count_next = count + CNT_W'(1);
    end else if (ctl.do_clear) begin
      count_next = count - CNT_W'(1);
    end
  end

  assign chain[0] = '0;

  for (genvar k = 0; k < TABLE_ENTRIES; k++) begin : g_cell
    logic [WORD_W-1:0] nb_word;
    logic [CPU_W-1:0]  nb_owner;

    if (k + 1 < TABLE_ENTRIES) begin : g_nb
      assign nb_word  = cell_word[k+1];
      assign nb_owner = cell_owner[k+1];
    end else begin : g_top
      assign nb_word  = cell_word[k];
      assign nb_owner = cell_owner[k];
    end

    eam_cell u_cell (
      .clk        (clk),
      .index      (IDX_W'(k)),
      .ctl        (ctl),
      .next_word  (nb_word),
      .next_owner (nb_owner),
      .chain_in   (chain[k]),
      .chain_out  (chain[k+1]),
      .word       (cell_word[k]),
      .owner      (cell_owner[k])
    );
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy     <= 1'b0;
      count    <= '0;
      m_tvalid <= 1'b0;
    end else begin
      busy  <= accept;
      count <= count_next;
      if (busy) begin
        m_tvalid <= 1'b1;
      end else if (m_tready) begin
        m_tvalid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      req_mode <= s_tdata[MODE_W-1:0];
      req_cpu  <= s_tdata[MODE_W +: CPU_W];
      req_word <= s_tdata[MODE_W + CPU_W + 2 +: WORD_W];
    end
    if (busy) begin
      res_fail      <= is_test && !chain[TABLE_ENTRIES].own;
      res_not_found <= is_clear && !hit;
      res_full      <= is_mark && !hit && is_full;
      res_occ       <= count_next[OCC_W-1:0];
    end
  end

  always_comb begin
    m_tdata = '0;
    m_tdata[OUT_BITS-1:0] = {res_occ, res_full, res_not_found, res_fail};
  end

endmodule

[design/eam_checker.sv]
// ----------------------------------------------------------------------------
// Exclusive access monitor port checker
// Watches the request and result channels of the top level over time.
// ----------------------------------------------------------------------------
module eam_checker
  import eam_pkg::*;
(
  input logic                   clk,
  input logic                   rst,
  input logic                   s_tvalid,
  input logic                   s_tready,
  input logic                   m_tvalid,
  input logic                   m_tready,
  input logic [OUT_TDATA_W-1:0] m_tdata
);

  logic s_beat;

  assign s_beat = s_tvalid && s_tready;

  a_result_held: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
    else $error("Stalled result beat changed or dropped.");

  a_one_at_a_time: assert property (@(posedge clk) disable iff (rst)
    s_beat |=> !s_tready)
    else $error("Request beat accepted while the previous one is in work.");

  a_result_follows: assert property (@(posedge clk) disable iff (rst)
    s_beat |-> ##2 m_tvalid)
    else $error("No result beat two cycles after a request beat.");

  a_occupancy_bound: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> (m_tdata[7:3] <= OCC_W'(TABLE_ENTRIES)))
    else $error("Reported occupancy exceeds the table size.");

endmodule

bind exclusive_access_monitor eam_checker u_eam_checker (
  .clk      (clk),
  .rst      (rst),
  .s_tvalid (s_tvalid),
  .s_tready (s_tready),
  .m_tvalid (m_tvalid),
  .m_tready (m_tready),
  .m_tdata  (m_tdata)
);
